// ===== hw/rtl/lpcd_pkg.sv =====
// Shared types and constants for the length-prefixed CAN deframer.
// No dependencies; compiled first.
package lpcd_pkg;

    // Payload limits of one frame.
    localparam int unsigned MAX_PAYLOAD  = 14;
    localparam int unsigned STORE_DEPTH  = 14;
    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned MAX_DLC      = 8;
    localparam int unsigned DATA_BYTES   = 8;

    // Width of the payload length and byte counters.
    localparam int unsigned LEN_W = 4;

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [7:0]       byte_t;

    // Input operation codes.
    typedef enum logic {
        OP_BYTE     = 1'b0,
        OP_NEW_CONN = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_BAD     = 2'd1,
        STATUS_FRAMING = 2'd2
    } status_t;

    // Framing phase, one-hot.
    typedef enum logic [3:0] {
        PH_HIGH = 4'b0001,
        PH_LOW  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_HALT = 4'b1000
    } phase_t;

endpackage

// ===== hw/rtl/lpcd_in_if.sv =====
// Valid/ready channel carrying one stream item (operation and byte).
// Depends on lpcd_pkg.
interface lpcd_in_if;
    import lpcd_pkg::*;

    logic  valid;
    logic  ready;
    op_t   op;
    byte_t stream_byte;

    modport source (output valid, output op, output stream_byte, input ready);
    modport sink (input valid, input op, input stream_byte, output ready);

endinterface

// ===== hw/rtl/lpcd_out_if.sv =====
// Valid/ready channel carrying one decoded CAN frame result.
// Depends on lpcd_pkg.
interface lpcd_out_if;
    import lpcd_pkg::*;

    logic        valid;
    logic        ready;
    status_t     status;
    logic [31:0] identifier;
    logic        extended_id;
    logic        remote_request;
    len_t        data_count;
    logic [63:0] data_bytes;

    modport source (
        output valid, output status, output identifier, output extended_id,
        output remote_request, output data_count, output data_bytes,
        input ready
    );
    modport sink (
        input valid, input status, input identifier, input extended_id,
        input remote_request, input data_count, input data_bytes,
        output ready
    );

endinterface

// ===== hw/rtl/length_prefixed_can_deframer.sv =====
// Length-prefixed CAN deframer: one stream byte per item, one result per frame.
// A result appears once the byte that completes its frame has passed the input
// register, then the result register. Throughput: one item every cycle unless
// result.ready stalls it, limited by the single framing-state update between them.
// Reset (rst_n low, asynchronous) returns to awaiting the high length byte with
// counts cleared and both registers empty; the payload store is not cleared.
// Depends on lpcd_pkg, lpcd_in_if and lpcd_out_if.
module length_prefixed_can_deframer (
    input  logic       clk,
    input  logic       rst_n,
    lpcd_in_if.sink    stream,
    lpcd_out_if.source result
);
    import lpcd_pkg::*;

    // Input register.
    logic  s1_valid_reg;
    op_t   s1_op_reg;
    byte_t s1_byte_reg;

    // Framing state.
    phase_t phase_reg, phase_next;
    byte_t  length_high_reg, length_high_next;
    len_t   payload_length_reg, payload_length_next;
    len_t   bytes_held_reg, bytes_held_next;
    byte_t  store_reg [STORE_DEPTH];
    logic   store_we;

    // Result register.
    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [31:0] identifier_reg, identifier_next;
    logic        extended_reg, extended_next;
    logic        remote_reg, remote_next;
    len_t        count_reg, count_next;
    logic [63:0] data_reg, data_next;
    logic        emit;

    logic advance;
    logic decode_go;
    len_t decode_len;
    byte_t view [STORE_DEPTH];
    byte_t dlc;
    logic [8:0] need_len;
    logic [4:0] held_inc;
    logic decode_bad;

    // Handshake: the input register moves whenever the result register can take.
    assign advance      = !out_valid_reg || result.ready;
    assign stream.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            s1_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            s1_op_reg   <= stream.op;
            s1_byte_reg <= stream.stream_byte;
        end
    end

    // Store view with the byte being written folded in, so a frame can be
    // decoded in the same cycle as its last payload byte.
    always_comb
    begin
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            if (phase_reg == PH_BODY && bytes_held_reg == LEN_W'(k))
            begin
                view[k] = s1_byte_reg;
            end
            else
            begin
                view[k] = store_reg[k];
            end
        end
    end

    // Payload decode.
    always_comb
    begin
        dlc        = view[5];
        need_len   = 9'(HEADER_BYTES) + {1'b0, dlc};
        decode_bad = ({5'b0, decode_len} < 9'(HEADER_BYTES))
                  || (dlc > 8'(MAX_DLC))
                  || ({5'b0, decode_len} < need_len);
        identifier_next = {view[0], view[1], view[2], view[3]};
        extended_next   = view[4][0];
        remote_next     = view[4][1];
        count_next      = dlc[LEN_W-1:0];
        for (int k = 0; k < DATA_BYTES; k++)
        begin
            if (8'(k) < dlc)
            begin
                data_next[63 - 8*k -: 8] = view[HEADER_BYTES + k];
            end
            else
            begin
                data_next[63 - 8*k -: 8] = 8'h00;
            end
        end
        status_next = STATUS_GOOD;
        if (decode_bad)
        begin
            status_next     = STATUS_BAD;
            identifier_next = '0;
            extended_next   = 1'b0;
            remote_next     = 1'b0;
            count_next      = '0;
            data_next       = '0;
        end
    end

    // Framing state update for the item in the input register.
    always_comb
    begin
        phase_next          = phase_reg;
        length_high_next    = length_high_reg;
        payload_length_next = payload_length_reg;
        bytes_held_next     = bytes_held_reg;
        store_we            = 1'b0;
        emit                = 1'b0;
        decode_go           = 1'b0;
        decode_len          = payload_length_reg;
        held_inc            = {1'b0, bytes_held_reg} + 5'd1;
        if (s1_op_reg == OP_NEW_CONN)
        begin
            phase_next          = PH_HIGH;
            length_high_next    = '0;
            payload_length_next = '0;
            bytes_held_next     = '0;
        end
        else
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    length_high_next = s1_byte_reg;
                    phase_next       = PH_LOW;
                end
                PH_LOW:
                begin
                    if (length_high_reg != 8'h00 || s1_byte_reg > 8'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_HALT;
                        emit       = 1'b1;
                    end
                    else
                    begin
                        payload_length_next = s1_byte_reg[LEN_W-1:0];
                        bytes_held_next     = '0;
                        if (s1_byte_reg == 8'h00)
                        begin
                            phase_next = PH_HIGH;
                            emit       = 1'b1;
                            decode_go  = 1'b1;
                            decode_len = '0;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    store_we        = 1'b1;
                    bytes_held_next = held_inc[LEN_W-1:0];
                    if (held_inc >= {1'b0, payload_length_reg})
                    begin
                        phase_next      = PH_HIGH;
                        bytes_held_next = '0;
                        emit            = 1'b1;
                        decode_go       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // State registers advance with the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HIGH;
            length_high_reg    <= '0;
            payload_length_reg <= '0;
            bytes_held_reg     <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            phase_reg          <= phase_next;
            length_high_reg    <= length_high_next;
            payload_length_reg <= payload_length_next;
            bytes_held_reg     <= bytes_held_next;
        end
    end

    // Payload store, written one byte at a time.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance && store_we)
        begin
            store_reg[bytes_held_reg] <= s1_byte_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && emit)
        begin
            if (decode_go)
            begin
                status_reg     <= status_next;
                identifier_reg <= identifier_next;
                extended_reg   <= extended_next;
                remote_reg     <= remote_next;
                count_reg      <= count_next;
                data_reg       <= data_next;
            end
            else
            begin
                status_reg     <= STATUS_FRAMING;
                identifier_reg <= '0;
                extended_reg   <= 1'b0;
                remote_reg     <= 1'b0;
                count_reg      <= '0;
                data_reg       <= '0;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.identifier     = identifier_reg;
    assign result.extended_id    = extended_reg;
    assign result.remote_request = remote_reg;
    assign result.data_count     = count_reg;
    assign result.data_bytes     = data_reg;

endmodule
